// ===== sv/vdma_pkg.sv =====
// vdma_pkg: shared types and constants for the vram dma command controller
// used by the front, queue, back and top modules; no dependencies
package vdma_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_MODE   = 2'd0;
   localparam logic [1:0] ACT_HBLANK = 2'd1;
   localparam logic [1:0] ACT_OAM    = 2'd2;

   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_VRAM = 2'd1;
   localparam logic [1:0] TGT_OAM  = 2'd2;

   localparam logic [11:0] OAM_BYTES   = 12'd160;
   localparam logic [11:0] BLOCK_BYTES = 12'd16;
   localparam logic [11:0] STALL_NORM  = 12'd8;
   localparam logic [11:0] STALL_FAST  = 12'd16;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_MODE_ARM,
      OP_MODE_GEN,
      OP_HBLANK,
      OP_OAM
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  count;
      logic [11:0] src_block;
      logic [8:0]  dst_block;
      logic        bank;
      logic [7:0]  page;
   } op_type;

endpackage

// ===== sv/vdma_front.sv =====
// vdma_front: accepts requests and decodes them into queued operations
// depends on vdma_pkg
module vdma_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_value,
   input  logic [15:0]           req_src_addr,
   input  logic [15:0]           req_dst_addr,
   input  logic                  req_vram_bank,
   input  logic                  q_full,
   output logic                  q_push,
   output vdma_pkg::op_type      q_op
);
   import vdma_pkg::*;

   always_comb begin
      q_op.count     = {1'b0, req_value[6:0]} + 8'd1;
      q_op.src_block = req_src_addr[15:4];
      q_op.dst_block = req_dst_addr[12:4];
      q_op.bank      = req_vram_bank;
      q_op.page      = req_value;
      case (req_action)
         ACT_MODE:   q_op.kind = req_value[7] ? OP_MODE_ARM : OP_MODE_GEN;
         ACT_HBLANK: q_op.kind = OP_HBLANK;
         ACT_OAM:    q_op.kind = OP_OAM;
         default:    q_op.kind = OP_NONE;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

endmodule

// ===== sv/vdma_queue.sv =====
// vdma_queue: short register queue between decode and execution
// depends on vdma_pkg
module vdma_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vdma_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output vdma_pkg::op_type head_op
);
   import vdma_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_op   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== sv/vdma_back.sv =====
// vdma_back: transfer state, command generation and result register
// depends on vdma_pkg
module vdma_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             q_not_empty,
   input  vdma_pkg::op_type q_op,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_copy_target,
   output logic [15:0]      rsp_copy_src,
   output logic [12:0]      rsp_copy_dst,
   output logic             rsp_copy_bank,
   output logic [11:0]      rsp_copy_bytes,
   output logic [11:0]      rsp_stall_cycles,
   output logic             rsp_busy_res,
   output logic [7:0]       rsp_blocks_left,
   output logic             rsp_irq_defer
);
   import vdma_pkg::*;

   logic        fast_mode_ff;
   logic        armed_ff, armed_in;
   logic [11:0] src_block_ff, src_block_in;
   logic [8:0]  dst_block_ff, dst_block_in;
   logic [7:0]  block_count_ff, block_count_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [1:0]  target_ff, target_in;
   logic [15:0] src_ff, src_in;
   logic [12:0] dst_ff, dst_in;
   logic        bank_ff, bank_in;
   logic [11:0] bytes_ff, bytes_in;
   logic [11:0] stall_ff, stall_in;
   logic        irq_ff, irq_in;

   logic [11:0] per_block;
   logic [11:0] gen_stall;
   logic [7:0]  count_dec;

   assign q_pop        = q_not_empty & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = q_pop | (rsp_valid_ff & rsp_stall);

   assign per_block = fast_mode_ff ? STALL_FAST : STALL_NORM;
   assign gen_stall = (fast_mode_ff ? {q_op.count, 4'b0000}
                                    : {1'b0, q_op.count, 3'b000}) + 12'd1;
   assign count_dec = block_count_ff - 8'd1;

   always_comb begin
      armed_in       = armed_ff;
      src_block_in   = src_block_ff;
      dst_block_in   = dst_block_ff;
      block_count_in = block_count_ff;
      target_in      = TGT_NONE;
      src_in         = '0;
      dst_in         = '0;
      bank_in        = 1'b0;
      bytes_in       = '0;
      stall_in       = '0;
      irq_in         = 1'b0;
      case (q_op.kind)
         OP_MODE_ARM: begin
            armed_in       = 1'b1;
            src_block_in   = q_op.src_block;
            dst_block_in   = q_op.dst_block;
            block_count_in = q_op.count;
         end
         OP_MODE_GEN: begin
            if (armed_ff) begin
               armed_in       = 1'b0;
               block_count_in = q_op.count;
            end else begin
               src_block_in   = q_op.src_block + {4'b0000, q_op.count};
               dst_block_in   = q_op.dst_block + {1'b0, q_op.count};
               block_count_in = '0;
               target_in      = TGT_VRAM;
               src_in         = {q_op.src_block, 4'b0000};
               dst_in         = {q_op.dst_block, 4'b0000};
               bank_in        = q_op.bank;
               bytes_in       = {q_op.count, 4'b0000};
               stall_in       = gen_stall;
               irq_in         = 1'b1;
            end
         end
         OP_HBLANK: begin
            if (armed_ff) begin
               src_block_in   = src_block_ff + 12'd1;
               dst_block_in   = dst_block_ff + 9'd1;
               block_count_in = count_dec;
               armed_in       = (count_dec != '0);
               target_in      = TGT_VRAM;
               src_in         = {src_block_ff, 4'b0000};
               dst_in         = {dst_block_ff, 4'b0000};
               bank_in        = q_op.bank;
               bytes_in       = BLOCK_BYTES;
               stall_in       = per_block;
            end
         end
         OP_OAM: begin
            target_in = TGT_OAM;
            src_in    = {q_op.page, 8'h00};
            bytes_in  = OAM_BYTES;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_mode_ff    <= 1'b0;
         armed_ff        <= 1'b0;
         src_block_ff    <= '0;
         dst_block_ff    <= '0;
         block_count_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fast_mode_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            armed_ff       <= armed_in;
            src_block_ff   <= src_block_in;
            dst_block_ff   <= dst_block_in;
            block_count_ff <= block_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         target_ff <= target_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         bank_ff   <= bank_in;
         bytes_ff  <= bytes_in;
         stall_ff  <= stall_in;
         irq_ff    <= irq_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_copy_target  = target_ff;
   assign rsp_copy_src     = src_ff;
   assign rsp_copy_dst     = dst_ff;
   assign rsp_copy_bank    = bank_ff;
   assign rsp_copy_bytes   = bytes_ff;
   assign rsp_stall_cycles = stall_ff;
   assign rsp_busy_res     = armed_ff;
   assign rsp_blocks_left  = block_count_ff;
   assign rsp_irq_defer    = irq_ff;

   armed_has_blocks: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (block_count_ff != '0))
      else $error("armed transfer with zero blocks");

   gen_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_op.kind == OP_MODE_GEN && !armed_ff)
         |=> (!armed_ff && block_count_ff == '0 && irq_ff))
      else $error("general transfer left state armed");

   irq_only_on_vram: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && irq_ff) |-> (target_ff == TGT_VRAM && !armed_ff))
      else $error("irq defer on a non general transfer");

   stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && !$past(q_pop)))
      else $error("result dropped or overwritten while stalled");

endmodule

// ===== sv/vram_dma_command_controller_top.sv =====
// vram_dma_command_controller_top: top level of the vram dma command controller
// depends on vdma_pkg, vdma_front, vdma_queue and vdma_back
//
//   port group   direction   handshake            payload
//   req_*        in          req_valid/req_stall  action, value, addresses, bank
//   rsp_*        out         rsp_valid/rsp_stall  one result per request
//   csr_*        in          csr_wr_en            fast mode bit
//
// one request per cycle while rsp_stall stays low; an accepted request is
// written into a queue entry and then into the back end result register
// a four entry queue absorbs back pressure before req_stall rises
// synchronous active high reset clears state, queue and result valid
module vram_dma_command_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_value,
   input  logic [15:0] req_src_addr,
   input  logic [15:0] req_dst_addr,
   input  logic        req_vram_bank,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_copy_target,
   output logic [15:0] rsp_copy_src,
   output logic [12:0] rsp_copy_dst,
   output logic        rsp_copy_bank,
   output logic [11:0] rsp_copy_bytes,
   output logic [11:0] rsp_stall_cycles,
   output logic        rsp_busy_res,
   output logic [7:0]  rsp_blocks_left,
   output logic        rsp_irq_defer
);
   import vdma_pkg::*;

   logic   q_full;
   logic   q_push;
   logic   q_pop;
   logic   q_not_empty;
   op_type push_op;
   op_type head_op;

   vdma_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_value     (req_value),
      .req_src_addr  (req_src_addr),
      .req_dst_addr  (req_dst_addr),
      .req_vram_bank (req_vram_bank),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_op          (push_op)
   );

   vdma_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (push_op),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_op   (head_op)
   );

   vdma_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .q_not_empty      (q_not_empty),
      .q_op             (head_op),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_copy_target  (rsp_copy_target),
      .rsp_copy_src     (rsp_copy_src),
      .rsp_copy_dst     (rsp_copy_dst),
      .rsp_copy_bank    (rsp_copy_bank),
      .rsp_copy_bytes   (rsp_copy_bytes),
      .rsp_stall_cycles (rsp_stall_cycles),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_blocks_left  (rsp_blocks_left),
      .rsp_irq_defer    (rsp_irq_defer)
   );

endmodule
